>>> rtl/core/sws_pkg.sv
// Shared types and codes for the sliding window sender.
package sws_pkg;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_ACK    = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_RESEND = 2'd3;

    localparam logic [1:0] KIND_NEW  = 2'd0;
    localparam logic [1:0] KIND_RETX = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [1:0] CFG_WINDOW  = 2'd0;
    localparam logic [1:0] CFG_SEGSIZE = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] total_segments;
        logic [31:0] ack_number;
    } cmd_word_t;

    typedef struct packed {
        logic [4:0]  window_limit;
        logic [15:0] segment_bytes;
        logic [31:0] timeout_ticks;
    } cfg_t;

endpackage

>>> rtl/core/sliding_window_sender.sv
// Sliding window sender for one connection. Command words (start, ack, tick,
// resend) are queued two deep and carried out one at a time by a sequencer.
// A tick or a stale ack is handled in the idle state; a resend first reads the
// ring of sequence numbers, a memory with a registered read, and then emits
// the segment. A start sends segments in turn while the window and the output
// register allow, and then arms the timer; an ack that slides the window frees
// and refills a single ring slot per cycle while the output register is free,
// and then arms the timer. Results leave through an output register, so the
// queue keeps accepting while a result waits to be taken.
module sliding_window_sender
    import sws_pkg::*;
#(
    parameter int RING_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] total_segments,
    input  logic [31:0] ack_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] seq_number,
    output logic [15:0] seg_size,
    output logic [1:0]  kind,
    output logic        last_of_run,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    cfg_t      cfg_reg;
    cmd_word_t in_word;
    cmd_word_t q_word;
    logic      q_valid;
    logic      q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_limit  <= 5'd5;
            cfg_reg.segment_bytes <= 16'd1460;
            cfg_reg.timeout_ticks <= 32'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW:  cfg_reg.window_limit  <= cfg_wdata[4:0];
                CFG_SEGSIZE: cfg_reg.segment_bytes <= cfg_wdata[15:0];
                CFG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_wdata;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_word.command        = command;
    assign in_word.total_segments = total_segments;
    assign in_word.ack_number     = ack_number;

    sws_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .q_valid  (q_valid),
        .q_word   (q_word),
        .q_pop    (q_pop)
    );

    sws_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .seq_number  (seq_number),
        .seg_size    (seg_size),
        .kind        (kind),
        .last_of_run (last_of_run)
    );

endmodule

>>> rtl/core/sws_front.sv
// Input side: accepts command words into a two-entry queue for the sequencer.
module sws_front
    import sws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  cmd_word_t   in_word,
    output logic        q_valid,
    output cmd_word_t   q_word,
    input  logic        q_pop
);

    cmd_word_t  slot_reg [2];
    logic       wptr_reg;
    logic       wptr_next;
    logic       rptr_reg;
    logic       rptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_word   = slot_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= in_word;
        end
    end

endmodule

>>> rtl/core/sws_back.sv
// Sequencer: carries out queued commands, keeps the window and emits result words.
module sws_back
    import sws_pkg::*;
#(
    parameter int RING_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  cmd_word_t   q_word,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] seq_number,
    output logic [15:0] seg_size,
    output logic [1:0]  kind,
    output logic        last_of_run
);

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEND   = 2'd1;
    localparam logic [1:0] ST_SLIDE  = 2'd2;
    localparam logic [1:0] ST_RESEND = 2'd3;

    logic [31:0] ring_mem [RING_DEPTH];

    logic [1:0]        state_reg, state_next;
    logic [31:0]       next_seq_reg, next_seq_next;
    logic [31:0]       base_reg, base_next;
    logic [CNT_W-1:0]  inflight_reg, inflight_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [31:0]       length_reg, length_next;
    logic              armed_reg, armed_next;
    logic [31:0]       left_reg, left_next;
    logic [31:0]       tseq_reg, tseq_next;
    logic              tv_reg, tv_next;
    logic [31:0]       toseq_reg, toseq_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_v_reg, pend_v_next;
    logic [31:0]       pend_seq_reg, pend_seq_next;
    logic [31:0]       rd_reg;
    logic              rd_en;

    logic              out_valid_reg;
    logic [31:0]       out_seq_reg;
    logic [15:0]       out_size_reg;
    logic [1:0]        out_kind_reg;
    logic              out_last_reg;

    logic              push;
    logic [31:0]       push_seq;
    logic [15:0]       push_size;
    logic [1:0]        push_kind;
    logic              push_last;

    logic              ring_we;
    logic [SLOT_W-1:0] ring_addr;

    logic              out_free;
    logic [4:0]        win5;
    logic [CNT_W-1:0]  eff_w;
    logic [31:0]       ack_clamp;
    logic [SLOT_W-1:0] head_inc;
    logic [CNT_W-1:0]  fl_dec;
    logic [CNT_W-1:0]  fl_use;
    logic [SLOT_W-1:0] head_use;
    logic [SUM_W-1:0]  slot_sum;
    logic [SLOT_W-1:0] slot_w;
    logic              can_send;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        win5 = cfg.window_limit;
        if (win5 == 5'd0)
        begin
            win5 = 5'd1;
        end
        else if (win5 > 5'(RING_DEPTH))
        begin
            win5 = 5'(RING_DEPTH);
        end
        eff_w = CNT_W'(win5);
    end

    always_comb
    begin
        head_inc = (head_reg == SLOT_W'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        fl_dec   = inflight_reg - 1'b1;
        // In the slide state the head moves on before the freed slot is refilled.
        head_use = (state_reg == ST_SLIDE) ? head_inc : head_reg;
        fl_use   = (state_reg == ST_SLIDE) ? fl_dec : inflight_reg;
        slot_sum = SUM_W'(head_use) + SUM_W'(fl_use);
        if (slot_sum >= SUM_W'(RING_DEPTH))
        begin
            slot_sum = slot_sum - SUM_W'(RING_DEPTH);
        end
        slot_w   = slot_sum[SLOT_W-1:0];
        can_send = (fl_use < eff_w) && (next_seq_reg < length_reg);
        ack_clamp = (q_word.ack_number > next_seq_reg) ? next_seq_reg : q_word.ack_number;
    end

    always_comb
    begin
        state_next    = state_reg;
        next_seq_next = next_seq_reg;
        base_next     = base_reg;
        inflight_next = inflight_reg;
        head_next     = head_reg;
        length_next   = length_reg;
        armed_next    = armed_reg;
        left_next     = left_reg;
        tseq_next     = tseq_reg;
        tv_next       = tv_reg;
        toseq_next    = toseq_reg;
        cnt_next      = cnt_reg;
        pend_v_next   = pend_v_reg;
        pend_seq_next = pend_seq_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        ring_we       = 1'b0;
        ring_addr     = slot_w;
        push          = 1'b0;
        push_seq      = pend_seq_reg;
        push_size     = cfg.segment_bytes;
        push_kind     = KIND_NEW;
        push_last     = 1'b0;

        if (out_free)
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        q_pop = 1'b1;
                        case (q_word.command)
                            CMD_START:
                            begin
                                length_next = q_word.total_segments;
                                state_next  = ST_SEND;
                            end
                            CMD_ACK:
                            begin
                                if (ack_clamp > base_reg)
                                begin
                                    if ((next_seq_reg >= length_reg) && (ack_clamp == next_seq_reg))
                                    begin
                                        next_seq_next = '0;
                                        base_next     = '0;
                                        inflight_next = '0;
                                        head_next     = '0;
                                        length_next   = '0;
                                        armed_next    = 1'b0;
                                        left_next     = '0;
                                        tseq_next     = '0;
                                        tv_next       = 1'b0;
                                        toseq_next    = '0;
                                        push          = 1'b1;
                                        push_seq      = ack_clamp;
                                        push_size     = '0;
                                        push_kind     = KIND_DONE;
                                        push_last     = 1'b1;
                                    end
                                    else
                                    begin
                                        cnt_next   = CNT_W'(ack_clamp - base_reg);
                                        base_next  = ack_clamp;
                                        state_next = ST_SLIDE;
                                    end
                                end
                            end
                            CMD_TICK:
                            begin
                                if (armed_reg)
                                begin
                                    if (left_reg <= 32'd1)
                                    begin
                                        tv_next    = 1'b1;
                                        toseq_next = tseq_reg;
                                        left_next  = cfg.timeout_ticks;
                                    end
                                    else
                                    begin
                                        left_next = left_reg - 32'd1;
                                    end
                                end
                            end
                            CMD_RESEND:
                            begin
                                if (tv_reg && (inflight_reg != '0) && (toseq_reg == base_reg))
                                begin
                                    rd_en      = 1'b1;
                                    state_next = ST_RESEND;
                                end
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SEND, ST_SLIDE:
                begin
                    if ((state_reg == ST_SEND) ? can_send : (cnt_reg != '0))
                    begin
                        if (state_reg == ST_SLIDE)
                        begin
                            head_next     = head_inc;
                            inflight_next = fl_dec;
                            cnt_next      = cnt_reg - 1'b1;
                        end
                        if (can_send)
                        begin
                            ring_we       = 1'b1;
                            inflight_next = fl_use + 1'b1;
                            next_seq_next = next_seq_reg + 32'd1;
                            // A held word goes out only once it is known not to be the last.
                            push          = pend_v_reg;
                            pend_v_next   = 1'b1;
                            pend_seq_next = next_seq_reg;
                        end
                    end
                    else
                    begin
                        armed_next  = 1'b1;
                        left_next   = cfg.timeout_ticks;
                        tseq_next   = base_reg;
                        push        = pend_v_reg;
                        push_last   = 1'b1;
                        pend_v_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
                ST_RESEND:
                begin
                    push       = 1'b1;
                    push_seq   = rd_reg;
                    push_kind  = KIND_RETX;
                    push_last  = 1'b1;
                    state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            next_seq_reg  <= '0;
            base_reg      <= '0;
            inflight_reg  <= '0;
            head_reg      <= '0;
            length_reg    <= '0;
            armed_reg     <= 1'b0;
            left_reg      <= '0;
            tseq_reg      <= '0;
            tv_reg        <= 1'b0;
            toseq_reg     <= '0;
            cnt_reg       <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            next_seq_reg <= next_seq_next;
            base_reg     <= base_next;
            inflight_reg <= inflight_next;
            head_reg     <= head_next;
            length_reg   <= length_next;
            armed_reg    <= armed_next;
            left_reg     <= left_next;
            tseq_reg     <= tseq_next;
            tv_reg       <= tv_next;
            toseq_reg    <= toseq_next;
            cnt_reg      <= cnt_next;
            pend_v_reg   <= pend_v_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_seq_reg <= pend_seq_next;
        if (push)
        begin
            out_seq_reg  <= push_seq;
            out_size_reg <= push_size;
            out_kind_reg <= push_kind;
            out_last_reg <= push_last;
        end
        if (ring_we)
        begin
            ring_mem[ring_addr] <= next_seq_reg;
        end
        if (rd_en)
        begin
            rd_reg <= ring_mem[head_reg];
        end
    end

    assign out_valid   = out_valid_reg;
    assign seq_number  = out_seq_reg;
    assign seg_size    = out_size_reg;
    assign kind        = out_kind_reg;
    assign last_of_run = out_last_reg;

endmodule

>>> rtl/core/sws_chk.sv
// Port checker for the sliding window sender, bound to the top level.
module sws_chk
    import sws_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] seq_number,
    input logic [15:0] seg_size,
    input logic [1:0]  kind,
    input logic        last_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(seq_number) && $stable(kind))
        else $error("stalled result word changed");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DONE |-> last_of_run)
        else $error("completion word is not the last of its run");

    a_done_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DONE |-> seg_size == 16'd0)
        else $error("completion word carries a segment size");

endmodule

bind sliding_window_sender sws_chk u_sws_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .seq_number  (seq_number),
    .seg_size    (seg_size),
    .kind        (kind),
    .last_of_run (last_of_run)
);

>>> tb/tb_sliding_window_sender.sv
// Self-checking testbench for the sliding window sender: directed and random command words.
`timescale 1ns / 1ps

module tb_sliding_window_sender;
    import sws_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 48;

    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] size;
        logic [1:0]  kind;
        logic        last;
    } segment_out_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [31:0] total_segments;
    logic [31:0] ack_number;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] seq_number;
    logic [15:0] seg_size;
    logic [1:0]  kind;
    logic        last_of_run;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    sliding_window_sender dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .total_segments(total_segments), .ack_number(ack_number),
        .out_valid(out_valid), .out_ready(out_ready),
        .seq_number(seq_number), .seg_size(seg_size), .kind(kind),
        .last_of_run(last_of_run),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Predicted state of the sender.
    logic [4:0]  win_cfg;
    logic [15:0] seg_cfg;
    logic [31:0] tout_cfg;
    logic [31:0] next_seq_p;
    logic [31:0] base_p;
    int unsigned flight_p;
    int unsigned head_p;
    logic [31:0] ring_p [DEPTH];
    logic [31:0] length_p;
    bit          armed_p;
    logic [31:0] left_p;
    logic [31:0] timer_seq_p;
    bit          timeout_p;
    logic [31:0] timeout_seq_p;

    segment_out_t expected_segments[$];
    segment_out_t run_q[$];

    int errors;
    int cycles = 0;
    int words_sent;
    int segments_checked;
    int retransmits_seen;
    int completions_seen;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int unsigned flight_cap();
        int unsigned w;
        w = win_cfg;
        if (w == 0)
            w = 1;
        if (w > DEPTH)
            w = DEPTH;
        return w;
    endfunction

    function automatic void clear_prediction();
        next_seq_p = '0;
        base_p = '0;
        flight_p = 0;
        head_p = 0;
        length_p = '0;
        armed_p = 1'b0;
        left_p = '0;
        timer_seq_p = '0;
        timeout_p = 1'b0;
        timeout_seq_p = '0;
    endfunction

    function automatic void fill_one_slot();
        segment_out_t s;
        if (flight_p >= flight_cap() || next_seq_p >= length_p)
            return;
        ring_p[(head_p + flight_p) % DEPTH] = next_seq_p;
        s.seq = next_seq_p;
        s.size = seg_cfg;
        s.kind = KIND_NEW;
        s.last = 1'b0;
        run_q.push_back(s);
        flight_p++;
        next_seq_p++;
    endfunction

    function automatic void arm_retx_timer();
        armed_p = 1'b1;
        left_p = tout_cfg;
        timer_seq_p = base_p;
    endfunction

    // Works out the segments that one accepted command word causes.
    function automatic void predict_segments(logic [1:0] cmd, logic [31:0] total,
                                             logic [31:0] ack);
        segment_out_t s;
        logic [31:0] acked;
        logic [31:0] count;
        run_q.delete();
        case (cmd)
            CMD_START:
            begin
                length_p = total;
                for (int i = 0; i < DEPTH; i++)
                    fill_one_slot();
                arm_retx_timer();
            end
            CMD_ACK:
            begin
                acked = (ack > next_seq_p) ? next_seq_p : ack;
                if (acked > base_p)
                begin
                    if (next_seq_p >= length_p && acked == next_seq_p)
                    begin
                        clear_prediction();
                        s.seq = acked;
                        s.size = '0;
                        s.kind = KIND_DONE;
                        s.last = 1'b0;
                        run_q.push_back(s);
                        completions_seen++;
                    end
                    else
                    begin
                        count = acked - base_p;
                        if (count > flight_p)
                            count = flight_p;
                        base_p = acked;
                        for (int unsigned i = 0; i < count; i++)
                        begin
                            head_p = (head_p + 1) % DEPTH;
                            flight_p--;
                            fill_one_slot();
                        end
                        arm_retx_timer();
                    end
                end
            end
            CMD_TICK:
            begin
                if (armed_p)
                begin
                    if (left_p <= 1)
                    begin
                        timeout_p = 1'b1;
                        timeout_seq_p = timer_seq_p;
                        left_p = tout_cfg;
                    end
                    else
                        left_p--;
                end
            end
            default:
            begin
                if (timeout_p && flight_p > 0 && timeout_seq_p == base_p)
                begin
                    s.seq = ring_p[head_p];
                    s.size = seg_cfg;
                    s.kind = KIND_RETX;
                    s.last = 1'b0;
                    run_q.push_back(s);
                    retransmits_seen++;
                end
            end
        endcase
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last = 1'b1;
        foreach (run_q[i])
            expected_segments.push_back(run_q[i]);
    endfunction

    // Offers one command word; valid stays high into the next word when no gap is drawn.
    task automatic send_word(logic [1:0] cmd, logic [31:0] total, logic [31:0] ack);
        @(negedge clk);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        command = cmd;
        total_segments = total;
        ack_number = ack;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_segments(cmd, total, ack);
        words_sent++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Waits until no segment is outstanding and the command queue has drained.
    task automatic wait_idle();
        drop_valid();
        while (expected_segments.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_wdata = value;
        case (index)
            CFG_WINDOW:  win_cfg = value[4:0];
            CFG_SEGSIZE: seg_cfg = value[15:0];
            default:     tout_cfg = value;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            out_ready = ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        segment_out_t got;
        segment_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {seq_number, seg_size, kind, last_of_run};
            if (expected_segments.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected word: seq %0d size %0d kind %0d last %0b",
                             got.seq, got.size, got.kind, got.last);
            end
            else
            begin
                want = expected_segments.pop_front();
                segments_checked++;
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"Mismatch: expected seq %0d size %0d kind %0d last %0b,",
                                  " got seq %0d size %0d kind %0d last %0b"},
                                 want.seq, want.size, want.kind, want.last,
                                 got.seq, got.size, got.kind, got.last);
                end
            end
        end
    end

    task automatic test_directed();
        send_word(CMD_START, 32'd0, 32'd0);
        send_word(CMD_TICK, 32'd0, 32'd0);
        send_word(CMD_START, 32'd3, 32'd0);
        send_word(CMD_ACK, 32'd0, 32'd0);
        send_word(CMD_RESEND, 32'd0, 32'd0);
        // An ack far beyond what was sent is clamped and completes the transfer.
        send_word(CMD_ACK, 32'd0, 32'hFFFF_FFFF);
        send_word(CMD_TICK, 32'd0, 32'd0);
        send_word(CMD_RESEND, 32'd0, 32'd0);
        wait_idle();
        write_reg(CFG_WINDOW, 32'd0);
        write_reg(CFG_SEGSIZE, 32'd0);
        write_reg(CFG_TIMEOUT, 32'd0);
        send_word(CMD_START, 32'd4, 32'd0);
        send_word(CMD_TICK, 32'd0, 32'd0);
        send_word(CMD_RESEND, 32'd0, 32'd0);
        send_word(CMD_ACK, 32'd0, 32'd1);
        send_word(CMD_RESEND, 32'd0, 32'd0);
        send_word(CMD_ACK, 32'd0, 32'd1);
        wait_idle();
        write_reg(CFG_WINDOW, 32'd31);
        write_reg(CFG_SEGSIZE, 32'hFFFF);
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        send_word(CMD_START, 32'd40, 32'd0);
        send_word(CMD_ACK, 32'd0, 32'd20);
        send_word(CMD_TICK, 32'd0, 32'd0);
        // A start that is not above what was sent sends nothing; it sets the length and rearms the timer.
        send_word(CMD_START, 32'd10, 32'd0);
        send_word(CMD_ACK, 32'd0, 32'd33);
        send_word(CMD_START, 32'hFFFF_FFFF, 32'd0);
        wait_idle();
    endtask

    // Mostly well-formed transfers, with a share of random noise words.
    task automatic test_random(int count);
        logic [1:0]  cmd;
        logic [31:0] total;
        logic [31:0] ack;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99, 0);
            total = $urandom;
            ack = $urandom;
            cmd = 2'($urandom_range(3, 0));
            if (pick < 80)
            begin
                pick = $urandom_range(99, 0);
                if (length_p == 0 || (next_seq_p >= length_p && flight_p == 0) || pick < 5)
                begin
                    cmd = CMD_START;
                    total = ($urandom_range(19, 0) == 0) ? $urandom : $urandom_range(60, 1);
                end
                else if (pick < 45 && flight_p > 0)
                begin
                    cmd = CMD_ACK;
                    ack = base_p + $urandom_range(flight_p, 1);
                end
                else if (pick < 52)
                begin
                    cmd = CMD_ACK;
                    ack = base_p - $urandom_range(2, 0);
                end
                else if (pick < 78)
                    cmd = CMD_TICK;
                else
                    cmd = CMD_RESEND;
            end
            send_word(cmd, total, ack);
        end
        wait_idle();
    endtask

    // The receiver holds off while a start and a run of acks arrive, so the block backs up.
    task automatic test_backpressure();
        @(posedge clk);
        hold_cycles = 400;
        send_word(CMD_START, 32'd200, 32'd0);
        for (int i = 1; i <= 12; i++)
            send_word(CMD_ACK, 32'd0, base_p + flight_p);
        wait_idle();
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        send_idle_pct = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_TICK;
        total_segments = '0;
        ack_number = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_WINDOW;
        cfg_wdata = '0;
        hold_cycles = 0;
        errors = 0;
        words_sent = 0;
        segments_checked = 0;
        retransmits_seen = 0;
        completions_seen = 0;
        win_cfg = 5'd5;
        seg_cfg = 16'd1460;
        tout_cfg = 32'd1000;
        clear_prediction();
        set_idling(0, 0);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();

        write_reg(CFG_WINDOW, 32'd3);
        write_reg(CFG_TIMEOUT, 32'd2);
        write_reg(CFG_SEGSIZE, 32'd512);
        test_random(110);

        set_idling(78, 0);
        write_reg(CFG_WINDOW, 32'd16);
        write_reg(CFG_TIMEOUT, 32'd1);
        test_random(110);

        set_idling(0, 78);
        write_reg(CFG_WINDOW, 32'd1);
        write_reg(CFG_TIMEOUT, 32'd3);
        write_reg(CFG_SEGSIZE, $urandom_range(65535, 0));
        test_random(110);

        set_idling(22, 22);
        write_reg(CFG_WINDOW, $urandom_range(31, 0));
        write_reg(CFG_TIMEOUT, 32'd0);
        test_random(110);

        $display("Sent %0d command words and checked %0d output words",
                 words_sent, segments_checked);
        $display("(%0d retransmissions, %0d completions) over windows 0 to 31 and timeouts 0 to max.",
                 retransmits_seen, completions_seen);
        if (errors == 0 && expected_segments.size() == 0)
            $display("All tests passed");
        else
        begin
            $display("%0d mismatches, %0d words still expected", errors,
                     expected_segments.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
